### hw/rtl/gp2c_pkg.sv
// Types, constants, microcode program and saturation helper for the primitive-to-conserved block.
package gp2c_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;

    typedef logic signed [WORD_BITS-1:0] t_word;

    localparam t_word WORD_MAX = 32'sh7FFF_FFFF;
    localparam t_word WORD_MIN = 32'sh8000_0000;
    localparam t_word ONE_Q    = t_word'(64'sd1 << FRAC_BITS);
    localparam t_word HALF_Q   = t_word'(64'sd1 << (FRAC_BITS - 1));
    localparam logic [17:0] GAMMA_RESET = 18'd87381;

    typedef struct packed {
        logic               op;
        logic [2:0]         metric_index;
        logic signed [31:0] metric_value;
        logic [30:0]        rho;
        logic [30:0]        press;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] field_x;
        logic signed [31:0] field_y;
        logic signed [31:0] field_z;
    } t_prim;

    typedef struct packed {
        logic signed [31:0] cons_density;
        logic signed [31:0] mom_x;
        logic signed [31:0] mom_y;
        logic signed [31:0] mom_z;
        logic signed [31:0] energy;
        logic [1:0]         status;
    } t_cons;

    // item opcodes
    localparam logic OPC_METRIC = 1'b0;
    localparam logic OPC_CONV   = 1'b1;

    // status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_SUPER = 2'd1;
    localparam logic [1:0] STS_RHO   = 2'd2;
    localparam logic [1:0] STS_SAT   = 2'd3;

    // micro-op codes
    localparam logic [3:0] UOP_LD   = 4'd0;
    localparam logic [3:0] UOP_MUL  = 4'd1;
    localparam logic [3:0] UOP_ADD  = 4'd2;
    localparam logic [3:0] UOP_SUB  = 4'd3;
    localparam logic [3:0] UOP_DIV  = 4'd4;
    localparam logic [3:0] UOP_SQRT = 4'd5;
    localparam logic [3:0] UOP_BGE  = 4'd6;
    localparam logic [3:0] UOP_BZ   = 4'd7;
    localparam logic [3:0] UOP_OUT  = 4'd8;
    localparam logic [3:0] UOP_END  = 4'd9;

    // load selectors
    localparam logic [3:0] LD_RHO   = 4'd0;
    localparam logic [3:0] LD_PRESS = 4'd1;
    localparam logic [3:0] LD_VX    = 4'd2;
    localparam logic [3:0] LD_VY    = 4'd3;
    localparam logic [3:0] LD_VZ    = 4'd4;
    localparam logic [3:0] LD_BX    = 4'd5;
    localparam logic [3:0] LD_BY    = 4'd6;
    localparam logic [3:0] LD_BZ    = 4'd7;
    localparam logic [3:0] LD_GAMMA = 4'd8;

    // register file map
    localparam logic [4:0] A_G0 = 5'd0,  A_G1 = 5'd1,  A_G2 = 5'd2;
    localparam logic [4:0] A_G3 = 5'd3,  A_G4 = 5'd4,  A_G5 = 5'd5;
    localparam logic [4:0] A_ONE = 5'd6, A_HALF = 5'd7;
    localparam logic [4:0] A_RHO = 5'd8, A_PRESS = 5'd9;
    localparam logic [4:0] A_VU0 = 5'd10, A_VU1 = 5'd11, A_VU2 = 5'd12;
    localparam logic [4:0] A_BU0 = 5'd13, A_BU1 = 5'd14, A_BU2 = 5'd15;
    localparam logic [4:0] A_GAMMA = 5'd16;
    localparam logic [4:0] A_VL0 = 5'd17, A_VL1 = 5'd18, A_VL2 = 5'd19;
    localparam logic [4:0] A_BL0 = 5'd20, A_BL1 = 5'd21, A_BL2 = 5'd22;
    localparam logic [4:0] A_V2 = 5'd23, A_B2 = 5'd24, A_BV = 5'd25;
    localparam logic [4:0] A_TA = 5'd26, A_TB = 5'd27, A_W = 5'd28;
    localparam logic [4:0] A_DENS = 5'd29, A_DHW = 5'd30;

    localparam logic [6:0] L_SUPER   = 7'd96;
    localparam logic [6:0] L_RHO     = 7'd97;
    localparam logic [6:0] PROG_LAST = 7'd97;

    typedef struct packed {
        logic [3:0] op;
        logic [4:0] a;
        logic [4:0] b;
        logic [4:0] dst;
        logic [3:0] arg;
        logic [6:0] tgt;
    } t_uop;

    typedef struct packed {
        logic  sat;
        t_word val;
    } t_sres;

    typedef struct packed {
        logic       start;
        logic [3:0] op;
    } t_alu_req;

    typedef struct packed {
        logic  done;
        logic  sat;
        t_word res;
    } t_alu_rsp;

    function automatic t_uop mk(input logic [3:0] op, input logic [4:0] a, input logic [4:0] b,
                                input logic [4:0] dst, input logic [3:0] arg,
                                input logic [6:0] tgt);
        t_uop u;
        u.op  = op;
        u.a   = a;
        u.b   = b;
        u.dst = dst;
        u.arg = arg;
        u.tgt = tgt;
        return u;
    endfunction

    function automatic t_uop m3(input logic [3:0] op, input logic [4:0] a, input logic [4:0] b,
                                input logic [4:0] dst);
        return mk(op, a, b, dst, 4'd0, 7'd0);
    endfunction

    // saturate a sign and magnitude into the word range
    function automatic t_sres sat_pack(input logic neg, input logic [48:0] mag);
        t_sres r;
        r.sat = 1'b0;
        r.val = '0;
        if (neg) begin
            if (mag > 49'h0_8000_0000) begin
                r.sat = 1'b1;
                r.val = WORD_MIN;
            end else begin
                r.val = t_word'(32'd0 - mag[31:0]);
            end
        end else begin
            if (mag > 49'h0_7FFF_FFFF) begin
                r.sat = 1'b1;
                r.val = WORD_MAX;
            end else begin
                r.val = t_word'(mag[31:0]);
            end
        end
        return r;
    endfunction

    function automatic t_uop prog(input logic [6:0] pc);
        t_uop u;
        case (pc)
            7'd0:  u = mk(UOP_LD, 5'd0, 5'd0, A_RHO,   LD_RHO,   7'd0);
            7'd1:  u = mk(UOP_LD, 5'd0, 5'd0, A_PRESS, LD_PRESS, 7'd0);
            7'd2:  u = mk(UOP_LD, 5'd0, 5'd0, A_VU0,   LD_VX,    7'd0);
            7'd3:  u = mk(UOP_LD, 5'd0, 5'd0, A_VU1,   LD_VY,    7'd0);
            7'd4:  u = mk(UOP_LD, 5'd0, 5'd0, A_VU2,   LD_VZ,    7'd0);
            7'd5:  u = mk(UOP_LD, 5'd0, 5'd0, A_BU0,   LD_BX,    7'd0);
            7'd6:  u = mk(UOP_LD, 5'd0, 5'd0, A_BU1,   LD_BY,    7'd0);
            7'd7:  u = mk(UOP_LD, 5'd0, 5'd0, A_BU2,   LD_BZ,    7'd0);
            7'd8:  u = mk(UOP_LD, 5'd0, 5'd0, A_GAMMA, LD_GAMMA, 7'd0);
            // lower velocity
            7'd9:  u = m3(UOP_MUL, A_G0, A_VU0, A_VL0);
            7'd10: u = m3(UOP_MUL, A_G1, A_VU1, A_TA);
            7'd11: u = m3(UOP_ADD, A_VL0, A_TA, A_VL0);
            7'd12: u = m3(UOP_MUL, A_G2, A_VU2, A_TA);
            7'd13: u = m3(UOP_ADD, A_VL0, A_TA, A_VL0);
            7'd14: u = m3(UOP_MUL, A_G1, A_VU0, A_VL1);
            7'd15: u = m3(UOP_MUL, A_G3, A_VU1, A_TA);
            7'd16: u = m3(UOP_ADD, A_VL1, A_TA, A_VL1);
            7'd17: u = m3(UOP_MUL, A_G4, A_VU2, A_TA);
            7'd18: u = m3(UOP_ADD, A_VL1, A_TA, A_VL1);
            7'd19: u = m3(UOP_MUL, A_G2, A_VU0, A_VL2);
            7'd20: u = m3(UOP_MUL, A_G4, A_VU1, A_TA);
            7'd21: u = m3(UOP_ADD, A_VL2, A_TA, A_VL2);
            7'd22: u = m3(UOP_MUL, A_G5, A_VU2, A_TA);
            7'd23: u = m3(UOP_ADD, A_VL2, A_TA, A_VL2);
            // lower field
            7'd24: u = m3(UOP_MUL, A_G0, A_BU0, A_BL0);
            7'd25: u = m3(UOP_MUL, A_G1, A_BU1, A_TA);
            7'd26: u = m3(UOP_ADD, A_BL0, A_TA, A_BL0);
            7'd27: u = m3(UOP_MUL, A_G2, A_BU2, A_TA);
            7'd28: u = m3(UOP_ADD, A_BL0, A_TA, A_BL0);
            7'd29: u = m3(UOP_MUL, A_G1, A_BU0, A_BL1);
            7'd30: u = m3(UOP_MUL, A_G3, A_BU1, A_TA);
            7'd31: u = m3(UOP_ADD, A_BL1, A_TA, A_BL1);
            7'd32: u = m3(UOP_MUL, A_G4, A_BU2, A_TA);
            7'd33: u = m3(UOP_ADD, A_BL1, A_TA, A_BL1);
            7'd34: u = m3(UOP_MUL, A_G2, A_BU0, A_BL2);
            7'd35: u = m3(UOP_MUL, A_G4, A_BU1, A_TA);
            7'd36: u = m3(UOP_ADD, A_BL2, A_TA, A_BL2);
            7'd37: u = m3(UOP_MUL, A_G5, A_BU2, A_TA);
            7'd38: u = m3(UOP_ADD, A_BL2, A_TA, A_BL2);
            // contractions
            7'd39: u = m3(UOP_MUL, A_VL0, A_VU0, A_V2);
            7'd40: u = m3(UOP_MUL, A_VL1, A_VU1, A_TA);
            7'd41: u = m3(UOP_ADD, A_V2, A_TA, A_V2);
            7'd42: u = m3(UOP_MUL, A_VL2, A_VU2, A_TA);
            7'd43: u = m3(UOP_ADD, A_V2, A_TA, A_V2);
            7'd44: u = m3(UOP_MUL, A_BL0, A_BU0, A_B2);
            7'd45: u = m3(UOP_MUL, A_BL1, A_BU1, A_TA);
            7'd46: u = m3(UOP_ADD, A_B2, A_TA, A_B2);
            7'd47: u = m3(UOP_MUL, A_BL2, A_BU2, A_TA);
            7'd48: u = m3(UOP_ADD, A_B2, A_TA, A_B2);
            7'd49: u = m3(UOP_MUL, A_BL0, A_VU0, A_BV);
            7'd50: u = m3(UOP_MUL, A_BL1, A_VU1, A_TA);
            7'd51: u = m3(UOP_ADD, A_BV, A_TA, A_BV);
            7'd52: u = m3(UOP_MUL, A_BL2, A_VU2, A_TA);
            7'd53: u = m3(UOP_ADD, A_BV, A_TA, A_BV);
            7'd54: u = mk(UOP_BGE, A_V2, A_ONE, 5'd0, 4'd0, L_SUPER);
            7'd55: u = mk(UOP_BZ, A_RHO, A_RHO, 5'd0, 4'd0, L_RHO);
            // Lorentz factor and enthalpy
            7'd56: u = m3(UOP_SUB, A_ONE, A_V2, A_TA);
            7'd57: u = m3(UOP_SQRT, A_TA, A_TA, A_TA);
            7'd58: u = m3(UOP_DIV, A_ONE, A_TA, A_W);
            7'd59: u = m3(UOP_SUB, A_GAMMA, A_ONE, A_TB);
            7'd60: u = m3(UOP_MUL, A_RHO, A_TB, A_TB);
            7'd61: u = m3(UOP_DIV, A_PRESS, A_TB, A_TB);
            7'd62: u = m3(UOP_ADD, A_ONE, A_TB, A_TB);
            7'd63: u = m3(UOP_DIV, A_PRESS, A_RHO, A_TA);
            7'd64: u = m3(UOP_ADD, A_TB, A_TA, A_TB);
            7'd65: u = m3(UOP_MUL, A_RHO, A_W, A_DENS);
            7'd66: u = m3(UOP_MUL, A_DENS, A_TB, A_TB);
            7'd67: u = m3(UOP_MUL, A_TB, A_W, A_DHW);
            7'd68: u = mk(UOP_OUT, A_DENS, A_DENS, 5'd0, 4'd0, 7'd0);
            // momentum
            7'd69: u = m3(UOP_MUL, A_DHW, A_VL0, A_TA);
            7'd70: u = m3(UOP_MUL, A_B2, A_VL0, A_TB);
            7'd71: u = m3(UOP_ADD, A_TA, A_TB, A_TA);
            7'd72: u = m3(UOP_MUL, A_BV, A_BL0, A_TB);
            7'd73: u = m3(UOP_SUB, A_TA, A_TB, A_TA);
            7'd74: u = mk(UOP_OUT, A_TA, A_TA, 5'd0, 4'd1, 7'd0);
            7'd75: u = m3(UOP_MUL, A_DHW, A_VL1, A_TA);
            7'd76: u = m3(UOP_MUL, A_B2, A_VL1, A_TB);
            7'd77: u = m3(UOP_ADD, A_TA, A_TB, A_TA);
            7'd78: u = m3(UOP_MUL, A_BV, A_BL1, A_TB);
            7'd79: u = m3(UOP_SUB, A_TA, A_TB, A_TA);
            7'd80: u = mk(UOP_OUT, A_TA, A_TA, 5'd0, 4'd2, 7'd0);
            7'd81: u = m3(UOP_MUL, A_DHW, A_VL2, A_TA);
            7'd82: u = m3(UOP_MUL, A_B2, A_VL2, A_TB);
            7'd83: u = m3(UOP_ADD, A_TA, A_TB, A_TA);
            7'd84: u = m3(UOP_MUL, A_BV, A_BL2, A_TB);
            7'd85: u = m3(UOP_SUB, A_TA, A_TB, A_TA);
            7'd86: u = mk(UOP_OUT, A_TA, A_TA, 5'd0, 4'd3, 7'd0);
            // energy
            7'd87: u = m3(UOP_ADD, A_ONE, A_V2, A_TA);
            7'd88: u = m3(UOP_MUL, A_B2, A_TA, A_TA);
            7'd89: u = m3(UOP_MUL, A_BV, A_BV, A_TB);
            7'd90: u = m3(UOP_SUB, A_TA, A_TB, A_TA);
            7'd91: u = m3(UOP_MUL, A_HALF, A_TA, A_TA);
            7'd92: u = m3(UOP_SUB, A_DHW, A_PRESS, A_TB);
            7'd93: u = m3(UOP_ADD, A_TB, A_TA, A_TA);
            7'd94: u = mk(UOP_OUT, A_TA, A_TA, 5'd0, 4'd4, 7'd0);
            7'd95: u = mk(UOP_END, 5'd0, 5'd0, 5'd0, {2'b00, STS_OK}, 7'd0);
            7'd96: u = mk(UOP_END, 5'd0, 5'd0, 5'd0, {2'b00, STS_SUPER}, 7'd0);
            7'd97: u = mk(UOP_END, 5'd0, 5'd0, 5'd0, {2'b00, STS_RHO}, 7'd0);
            default: u = mk(UOP_END, 5'd0, 5'd0, 5'd0, {2'b00, STS_OK}, 7'd0);
        endcase
        return u;
    endfunction

endpackage

### hw/rtl/gp2c_alu.sv
// Shared arithmetic unit: saturating multiply, add and subtract; bit-serial divide and square root.
module gp2c_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gp2c_pkg::t_alu_req i_req,
    input  gp2c_pkg::t_word    i_a,
    input  gp2c_pkg::t_word    i_b,
    output gp2c_pkg::t_alu_rsp o_rsp
);
    import gp2c_pkg::*;

    localparam int NUM_BITS   = WORD_BITS + FRAC_BITS;
    localparam int SQRT_STEPS = NUM_BITS / 2;

    logic [31:0] ma, mb;
    logic [63:0] prod;
    logic [64:0] rl;
    t_word       nb, opnd;
    logic        nsat;
    logic [32:0] sum, smag;
    t_sres       s_mul, s_add, s_fin;
    logic        is_iter;

    logic [NUM_BITS-1:0] r_num, r_quo;
    logic [33:0]         r_rem, raw, trial;
    logic [31:0]         r_den;
    logic [5:0]          r_cnt;
    logic                r_busy, r_neg, r_zero, r_sqrt, ge;

    always_comb begin
        ma    = i_a[31] ? 32'd0 - i_a : i_a;
        mb    = i_b[31] ? 32'd0 - i_b : i_b;
        prod  = ma * mb;
        rl    = {1'b0, prod} + 65'(64'd1 << (FRAC_BITS - 1));
        s_mul = sat_pack(i_a[31] ^ i_b[31], rl[64:16]);
        // negating the most negative word saturates
        nsat  = (i_b == WORD_MIN);
        nb    = nsat ? WORD_MAX : t_word'(32'd0 - i_b);
        opnd  = (i_req.op == UOP_SUB) ? nb : i_b;
        sum   = {i_a[31], i_a} + {opnd[31], opnd};
        smag  = sum[32] ? 33'd0 - sum : sum;
        s_add = sat_pack(sum[32], {16'd0, smag});
        if (i_req.op == UOP_SUB) begin
            s_add.sat = s_add.sat | nsat;
        end
    end

    always_comb begin
        if (r_sqrt) begin
            raw   = {r_rem[31:0], r_num[NUM_BITS-1 -: 2]};
            trial = {8'd0, r_quo[SQRT_STEPS-1:0], 2'b01};
        end else begin
            raw   = {r_rem[32:0], r_num[NUM_BITS-1]};
            trial = {2'd0, r_den};
        end
        ge = (raw >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_sqrt <= (i_req.op == UOP_SQRT);
            r_zero <= (i_req.op == UOP_DIV) && (i_b == '0);
            r_neg  <= (i_b == '0) ? i_a[31] : (i_a[31] ^ i_b[31]);
            r_den  <= mb;
            r_rem  <= '0;
            r_quo  <= '0;
            if (i_req.op == UOP_SQRT) begin
                r_num <= {i_a[31:0], {FRAC_BITS{1'b0}}};
                r_cnt <= 6'(SQRT_STEPS);
            end else begin
                r_num <= {ma, {FRAC_BITS{1'b0}}};
                r_cnt <= (i_b == '0) ? 6'd0 : 6'(NUM_BITS);
            end
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_rem <= ge ? raw - trial : raw;
                r_quo <= {r_quo[NUM_BITS-2:0], ge};
                r_num <= r_sqrt ? {r_num[NUM_BITS-3:0], 2'b00} : {r_num[NUM_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_sqrt) begin
            s_fin.sat = 1'b0;
            s_fin.val = t_word'({8'd0, r_quo[SQRT_STEPS-1:0]});
        end else if (r_zero) begin
            s_fin = sat_pack(r_neg, '1);
        end else begin
            s_fin = sat_pack(r_neg, {1'b0, r_quo});
        end
        is_iter = (i_req.op == UOP_DIV) || (i_req.op == UOP_SQRT);
        o_rsp.done = is_iter ? (r_busy && (r_cnt == '0) && !i_req.start) : 1'b1;
        if (is_iter) begin
            o_rsp.sat = s_fin.sat;
            o_rsp.res = s_fin.val;
        end else if (i_req.op == UOP_MUL) begin
            o_rsp.sat = s_mul.sat;
            o_rsp.res = s_mul.val;
        end else begin
            o_rsp.sat = s_add.sat;
            o_rsp.res = s_add.val;
        end
    end

endmodule

### hw/rtl/grmhd_prim_to_cons.sv
// Top level: microcoded primitive-to-conserved converter with metric store and output register.
// A metric write item is written to the register file as it is accepted; a conversion item runs the
// microcode program: each step reads the register file, then executes, and the three divides
// and the square root also wait on the shared arithmetic unit. Early exits branch to an end step.
// One item is in work at a time; the result register frees the sequencer while a result waits.
// Reset is synchronous, active low; after it an init pass loads the identity metric and
// constants into the register file, during which items are stalled (config writes still taken).
module grmhd_prim_to_cons (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  gp2c_pkg::t_prim i_item,
    output logic            o_valid,
    input  logic            i_stall,
    output gp2c_pkg::t_cons o_item,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [17:0]     i_cfg_data
);
    import gp2c_pkg::*;

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_EX   = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;

    logic [2:0]  r_state;
    logic [2:0]  r_init;
    logic [6:0]  r_pc;
    logic        r_sat;
    logic [17:0] r_gamma;
    t_prim       r_in;
    t_word       r_res [5];
    t_cons       r_out;
    logic        r_out_valid;
    t_word       r_ra, r_rb;
    t_word       mem [32];

    t_uop     uop;
    t_alu_req alu_req;
    t_alu_rsp alu_rsp;
    logic     w_en;
    logic [4:0] w_addr;
    t_word    w_data, ld_val;
    logic     in_acc, out_free;

    assign uop         = prog(r_pc);
    assign o_stall     = (r_state != ST_IDLE);
    assign in_acc      = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;
    assign o_valid     = r_out_valid;
    assign o_item      = r_out;
    assign o_cfg_ready = 1'b1;

    assign alu_req.op    = uop.op;
    assign alu_req.start = (r_state == ST_EX) && ((uop.op == UOP_DIV) || (uop.op == UOP_SQRT));

    gp2c_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (r_ra),
        .i_b     (r_rb),
        .o_rsp   (alu_rsp)
    );

    always_comb begin
        case (uop.arg)
            LD_RHO:   ld_val = t_word'({1'b0, r_in.rho});
            LD_PRESS: ld_val = t_word'({1'b0, r_in.press});
            LD_VX:    ld_val = r_in.vel_x;
            LD_VY:    ld_val = r_in.vel_y;
            LD_VZ:    ld_val = r_in.vel_z;
            LD_BX:    ld_val = r_in.field_x;
            LD_BY:    ld_val = r_in.field_y;
            LD_BZ:    ld_val = r_in.field_z;
            LD_GAMMA: ld_val = t_word'({14'd0, r_gamma});
            default:  ld_val = '0;
        endcase
    end

    always_comb begin
        w_en   = 1'b0;
        w_addr = uop.dst;
        w_data = alu_rsp.res;
        case (r_state)
            ST_INIT: begin
                w_en   = 1'b1;
                w_addr = {2'b00, r_init};
                // identity metric, then one and one half
                if ({2'b00, r_init} == A_G0 || {2'b00, r_init} == A_G3 ||
                    {2'b00, r_init} == A_G5 || {2'b00, r_init} == A_ONE) begin
                    w_data = ONE_Q;
                end else if ({2'b00, r_init} == A_HALF) begin
                    w_data = HALF_Q;
                end else begin
                    w_data = '0;
                end
            end
            ST_IDLE: begin
                w_en   = in_acc && (i_item.op == OPC_METRIC) && (i_item.metric_index < 3'd6);
                w_addr = {2'b00, i_item.metric_index};
                w_data = i_item.metric_value;
            end
            ST_EX: begin
                if (uop.op == UOP_LD) begin
                    w_en   = 1'b1;
                    w_data = ld_val;
                end else if (uop.op == UOP_MUL || uop.op == UOP_ADD || uop.op == UOP_SUB) begin
                    w_en = 1'b1;
                end
            end
            ST_WAIT: w_en = alu_rsp.done;
            default: w_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        if (r_state == ST_RD) begin
            r_ra <= mem[uop.a];
            r_rb <= mem[uop.b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_init      <= '0;
            r_pc        <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
            r_gamma     <= GAMMA_RESET;
        end else begin
            if (r_out_valid && !i_stall && !((r_state == ST_EX) && (uop.op == UOP_END))) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_gamma <= i_cfg_data;
            end
            case (r_state)
                ST_INIT: begin
                    r_init <= r_init + 3'd1;
                    if (r_init == 3'd7) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc && (i_item.op == OPC_CONV)) begin
                        r_in    <= i_item;
                        r_pc    <= '0;
                        r_sat   <= 1'b0;
                        r_state <= ST_RD;
                    end
                end
                ST_RD: r_state <= ST_EX;
                ST_EX: begin
                    case (uop.op)
                        UOP_LD: begin
                            r_pc    <= r_pc + 7'd1;
                            r_state <= ST_RD;
                        end
                        UOP_MUL, UOP_ADD, UOP_SUB: begin
                            r_sat   <= r_sat | alu_rsp.sat;
                            r_pc    <= r_pc + 7'd1;
                            r_state <= ST_RD;
                        end
                        UOP_DIV, UOP_SQRT: r_state <= ST_WAIT;
                        UOP_BGE: begin
                            r_pc    <= (r_ra >= r_rb) ? uop.tgt : r_pc + 7'd1;
                            r_state <= ST_RD;
                        end
                        UOP_BZ: begin
                            r_pc    <= (r_ra == '0) ? uop.tgt : r_pc + 7'd1;
                            r_state <= ST_RD;
                        end
                        UOP_OUT: begin
                            r_res[uop.arg[2:0]] <= r_ra;
                            r_pc    <= r_pc + 7'd1;
                            r_state <= ST_RD;
                        end
                        UOP_END: begin
                            // hold until the result register can take the item
                            if (out_free) begin
                                r_out_valid <= 1'b1;
                                r_state     <= ST_IDLE;
                                if (uop.arg[1:0] == STS_OK) begin
                                    r_out.cons_density <= r_res[0];
                                    r_out.mom_x        <= r_res[1];
                                    r_out.mom_y        <= r_res[2];
                                    r_out.mom_z        <= r_res[3];
                                    r_out.energy       <= r_res[4];
                                    r_out.status       <= r_sat ? STS_SAT : STS_OK;
                                end else begin
                                    r_out.cons_density <= '0;
                                    r_out.mom_x        <= '0;
                                    r_out.mom_y        <= '0;
                                    r_out.mom_z        <= '0;
                                    r_out.energy       <= '0;
                                    r_out.status       <= uop.arg[1:0];
                                end
                            end
                        end
                        default: r_state <= ST_IDLE;
                    endcase
                end
                ST_WAIT: begin
                    if (alu_rsp.done) begin
                        r_sat   <= r_sat | alu_rsp.sat;
                        r_pc    <= r_pc + 7'd1;
                        r_state <= ST_RD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_wait_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT) |-> ((uop.op == UOP_DIV) || (uop.op == UOP_SQRT)))
        else $error("sequencer waits on a single-cycle op");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc <= PROG_LAST))
        else $error("program counter beyond program");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_EX) && ($past(uop.op) == UOP_END))
        else $error("result loaded outside the end step");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_item.status == STS_SUPER) || (o_item.status == STS_RHO))) |->
        ((o_item.cons_density == '0) && (o_item.energy == '0) && (o_item.mom_x == '0)))
        else $error("error result carries nonzero values");

endmodule
